// File: hdl/tksd_pkg.sv
// Shared types and constants for the terminal key sequence decoder.
package tksd_pkg;

   localparam int BYTE_W = 8;
   localparam int CODE_W = 11;

   localparam logic [CODE_W-1:0] CODE_ESC = 11'd27;

   typedef struct packed {
      logic              pair;
      logic [CODE_W-1:0] code;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

// File: hdl/terminal_key_sequence_decoder.sv
// Top level of the terminal key sequence decoder: register port, parser, queue and result stage.
//
// Bytes enter through req_push/req_full: a byte is taken at an edge with req_push high and
// req_full low. Results leave through rsp_empty/rsp_pop: the oldest result sits on
// rsp_key_code and rsp_last_of_run while rsp_empty is low and is taken with rsp_pop.
// Each byte gives zero, one or two results; rsp_last_of_run marks the last one of a byte.
// The parser takes one byte per cycle while req_full is low. A result that a byte completes is
// written to the queue and then loaded into the output register, when nothing waits ahead of it.
// Single results leave at one per cycle while rsp_pop stays high; an escape followed by a plain
// byte gives two results, the escape code and then the byte's code. Between parser and output sits
// a queue of QueueDepth entries, so bytes keep flowing while the receiver stalls; req_full rises
// once the queue is full and falls the cycle after the result stage next takes an entry from it.
// The mode register (byte address 0, bit 0) picks VT/ANSI decoding (0) or DOS scan codes
// (1); writing it drops any sequence in progress. Write it only while the block is idle.
// Reset clears the mode to VT/ANSI, empties the queue and output, and returns the parser
// to idle.
module terminal_key_sequence_decoder #(
   parameter int QueueDepth = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [tksd_pkg::BYTE_W-1:0] req_key_byte,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [tksd_pkg::CODE_W-1:0] rsp_key_code,
   output logic                        rsp_last_of_run,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import tksd_pkg::*;

   localparam logic CSR_IDX_MODE = 1'b0;

   logic      accept;
   logic      mode_we;
   logic      mode;
   push_type  push;
   entry_type q_head;
   logic      q_empty;
   logic      q_pop;

   assign csr_pready = 1'b1;
   assign mode_we    = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_MODE);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MODE) ? {31'd0, mode} : 32'd0;

   assign accept = req_push && !req_full;

   tksd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode_we    (mode_we),
      .mode_wdata (csr_pwdata[0]),
      .accept     (accept),
      .key_byte   (req_key_byte),
      .mode       (mode),
      .push       (push)
   );

   tksd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .full  (req_full),
      .empty (q_empty),
      .head  (q_head)
   );

   tksd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_key_code    (rsp_key_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: hdl/tksd_front.sv
// Front end: mode register and byte parser that turns accepted bytes into queue entries.
module tksd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       mode_we,
   input  logic                       mode_wdata,
   input  logic                       accept,
   input  logic [tksd_pkg::BYTE_W-1:0] key_byte,
   output logic                       mode,
   output tksd_pkg::push_type         push
);
   import tksd_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_ESC  = 3'd1;
   localparam logic [2:0] PH_CSI  = 3'd2;
   localparam logic [2:0] PH_ONE  = 3'd3;
   localparam logic [2:0] PH_TWO  = 3'd4;
   localparam logic [2:0] PH_SKIP = 3'd5;
   localparam logic [2:0] PH_D224 = 3'd6;
   localparam logic [2:0] PH_D000 = 3'd7;

   logic              mode_ff;
   logic [2:0]        phase_ff, phase_in;
   logic [CODE_W-1:0] held_ff, held_in;
   logic [CODE_W-1:0] b_ext;
   logic              emit;
   logic              pair;
   logic [CODE_W-1:0] code;

   assign b_ext = {{(CODE_W-BYTE_W){1'b0}}, key_byte};

   always_comb begin
      phase_in = PH_IDLE;
      held_in  = held_ff;
      emit     = 1'b1;
      pair     = 1'b0;
      code     = b_ext;
      if (mode_ff) begin
         case (phase_ff)
            PH_D224: code = 11'd500 + b_ext;
            PH_D000: code = 11'd942 + b_ext;
            default: begin
               if (key_byte == 8'd224) begin
                  phase_in = PH_D224;
                  emit     = 1'b0;
               end else if (key_byte == 8'd0) begin
                  phase_in = PH_D000;
                  emit     = 1'b0;
               end
            end
         endcase
      end else begin
         case (phase_ff)
            PH_ESC: begin
               if (key_byte == 8'd91) begin
                  phase_in = PH_CSI;
                  emit     = 1'b0;
               end else begin
                  pair = 1'b1;
               end
            end
            PH_CSI: begin
               case (key_byte)
                  8'd65: code = 11'd572;
                  8'd66: code = 11'd580;
                  8'd67: code = 11'd577;
                  8'd68: code = 11'd575;
                  8'd49: begin
                     phase_in = PH_ONE;
                     emit     = 1'b0;
                  end
                  8'd50: begin
                     phase_in = PH_TWO;
                     emit     = 1'b0;
                  end
                  8'd51: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd583;
                     emit     = 1'b0;
                  end
                  8'd52: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd579;
                     emit     = 1'b0;
                  end
                  8'd53: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd573;
                     emit     = 1'b0;
                  end
                  8'd54: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd581;
                     emit     = 1'b0;
                  end
                  default: code = b_ext;
               endcase
            end
            PH_ONE: begin
               if (key_byte == 8'd126) begin
                  code = 11'd571;
               end else if (key_byte >= 8'd49 && key_byte <= 8'd53) begin
                  phase_in = PH_SKIP;
                  held_in  = 11'd952 + b_ext;
                  emit     = 1'b0;
               end else if (key_byte >= 8'd55 && key_byte <= 8'd57) begin
                  phase_in = PH_SKIP;
                  held_in  = 11'd951 + b_ext;
                  emit     = 1'b0;
               end
            end
            PH_TWO: begin
               case (key_byte)
                  8'd126: code = 11'd582;
                  8'd48: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd1009;
                     emit     = 1'b0;
                  end
                  8'd49: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd1010;
                     emit     = 1'b0;
                  end
                  8'd51: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd633;
                     emit     = 1'b0;
                  end
                  8'd52: begin
                     phase_in = PH_SKIP;
                     held_in  = 11'd634;
                     emit     = 1'b0;
                  end
                  default: code = b_ext;
               endcase
            end
            PH_SKIP: code = held_ff;
            default: begin
               if (key_byte == 8'd127) begin
                  code = 11'd8;
               end else if (key_byte == 8'd27) begin
                  phase_in = PH_ESC;
                  emit     = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else if (mode_we) begin
         mode_ff  <= mode_wdata;
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   assign mode             = mode_ff;
   assign push.valid       = accept && emit && !mode_we;
   assign push.entry.pair  = pair;
   assign push.entry.code  = code;

   // A mode write always abandons any sequence in progress.
   assert property (@(posedge clock) disable iff (reset) mode_we |=> phase_ff == PH_IDLE)
      else $error("phase not idle after mode write");

   // DOS mode only ever uses the idle and prefix phases.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff |-> (phase_ff == PH_IDLE || phase_ff == PH_D224 || phase_ff == PH_D000))
      else $error("VT phase reached in DOS mode");

   // A two-result entry only comes from an escape followed by a plain byte.
   assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.entry.pair) |-> (phase_ff == PH_ESC && !mode_ff))
      else $error("pair entry outside escape phase");

endmodule

// File: hdl/tksd_queue.sv
// Short queue of decoded entries between the parser and the result stage.
module tksd_queue #(
   parameter int Depth = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tksd_pkg::push_type   push,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output tksd_pkg::entry_type  head
);
   import tksd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type        mem [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push.valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push.valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

endmodule

// File: hdl/tksd_back.sv
// Result stage: expands queue entries into result items held in an output register.
module tksd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  tksd_pkg::entry_type         q_head,
   output logic                        q_pop,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [tksd_pkg::CODE_W-1:0] rsp_key_code,
   output logic                        rsp_last_of_run
);
   import tksd_pkg::*;

   logic              valid_ff;
   logic [CODE_W-1:0] code_ff;
   logic              last_ff;
   logic              pend_ff;
   logic [CODE_W-1:0] pend_code_ff;
   logic              load;

   assign load  = !valid_ff || rsp_pop;
   assign q_pop = load && !pend_ff && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (load) begin
         if (pend_ff) begin
            valid_ff <= 1'b1;
            pend_ff  <= 1'b0;
         end else begin
            valid_ff <= !q_empty;
            pend_ff  <= !q_empty && q_head.pair;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (pend_ff) begin
            code_ff <= pend_code_ff;
            last_ff <= 1'b1;
         end else begin
            code_ff      <= q_head.pair ? CODE_ESC : q_head.code;
            last_ff      <= !q_head.pair;
            pend_code_ff <= q_head.code;
         end
      end
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_key_code    = code_ff;
   assign rsp_last_of_run = last_ff;

endmodule
